/* rtl/core/rectangle_union_area_sweep_macros.svh */
// Assertion macros shared by the rectangle union area sweep RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef RECTANGLE_UNION_AREA_SWEEP_MACROS_SVH
`define RECTANGLE_UNION_AREA_SWEEP_MACROS_SVH
`ifndef SYNTH
`define RUA_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rua: assertion failed");
`define RUA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rua: assertion failed");
`else
`define RUA_ASSERT(label, clk, rst, ante, cons)
`define RUA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/rua_pkg.sv */
// Shared types, constants and helpers for the rectangle union area sweep.
// No dependencies; imported by every module of the block.
`default_nettype none
package rua_pkg;

   localparam int MAX_ROWS  = 1024;
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int CNT_W     = $clog2(MAX_ROWS + 1);
   localparam int X_W       = 32;
   localparam int CFG_W     = 11;
   localparam int COVER_W   = 16;
   localparam int AREA_W    = 63;
   localparam int COVROW_W  = 11;
   localparam int ROWF_W    = 10;
   localparam int PROD_W    = X_W + CNT_W;
   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 80;
   localparam int RESET_ROWS = 1024;

   localparam logic [COVER_W-1:0] COVER_MAX = {COVER_W{1'b1}};
   localparam logic [AREA_W-1:0]  AREA_MAX  = {AREA_W{1'b1}};

   typedef logic [COVER_W-1:0] cover_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RECOUNT,
      ST_SPAN,
      ST_FINISH
   } sweep_state_type;

   typedef struct packed {
      logic             wr_en;
      logic [ROW_W-1:0] wr_addr;
      cover_type        wr_data;
      logic             rd_en;
      logic [ROW_W-1:0] rd_addr;
   } mem_cmd_type;

   typedef struct packed {
      logic             start;
      logic [X_W-1:0]   event_x;
      logic             first;
      logic [CNT_W-1:0] covered;
   } area_cmd_type;

   function automatic cover_type cover_next(input cover_type old, input logic closing);
      cover_type res;
      res = old;
      if (closing) begin
         if (old != '0) res = old - cover_type'(1);
      end else begin
         if (old != COVER_MAX) res = old + cover_type'(1);
      end
      return res;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/rua_cover_mem.sv */
// Per-row cover count store: one write port, one registered read port.
// Depends on rua_pkg for depth and word type.
`default_nettype none
module rua_cover_mem (
   input  wire                  clock,
   input  rua_pkg::mem_cmd_type cmd,
   output rua_pkg::cover_type   rd_data
);
   import rua_pkg::*;

   cover_type cover_ff [MAX_ROWS];
   cover_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         cover_ff[cmd.wr_addr] <= cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= cover_ff[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/core/rua_area_unit.sv */
// Area accumulator: x step times covered rows, then a saturating add.
// Two register stages; depends on rua_pkg.
`default_nettype none
module rua_area_unit (
   input  wire                           clock,
   input  wire                           reset,
   input  rua_pkg::area_cmd_type         cmd,
   output logic [rua_pkg::AREA_W-1:0]    area
);
   import rua_pkg::*;

   logic [X_W-1:0]    prev_x_ff, prev_x_in;
   logic [AREA_W-1:0] area_ff, area_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              stage_ff, stage_in;

   logic [X_W-1:0]    prev_eff;
   logic [X_W:0]      diff;
   logic              diff_pos;
   logic [AREA_W:0]   sum;

   always_comb begin
      prev_eff = cmd.first ? cmd.event_x : prev_x_ff;
      diff     = {cmd.event_x[X_W-1], cmd.event_x} - {prev_eff[X_W-1], prev_eff};
      diff_pos = !diff[X_W] && (diff != '0);
      prod_in  = diff_pos ? (PROD_W'(diff[X_W-1:0]) * PROD_W'(cmd.covered)) : '0;
      stage_in = cmd.start;
      prev_x_in = cmd.start ? cmd.event_x : prev_x_ff;
      sum      = {1'b0, area_ff} + (AREA_W + 1)'(prod_ff);
      area_in  = area_ff;
      if (cmd.start && cmd.first) begin
         area_in = '0;
      end else if (stage_ff) begin
         area_in = sum[AREA_W] ? AREA_MAX : sum[AREA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= '0;
         area_ff   <= '0;
         stage_ff  <= 1'b0;
      end else begin
         prev_x_ff <= prev_x_in;
         area_ff   <= area_in;
         stage_ff  <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         prod_ff <= prod_in;
      end
   end

   assign area = area_ff;

endmodule
`default_nettype wire

/* rtl/core/rua_sweep_ctrl.sv */
// Sweep sequencer: clearing pass, span read-modify-write walk, covered row
// recount and the result register. Depends on rua_pkg and the macro header.
`default_nettype none
`include "rectangle_union_area_sweep_macros.svh"
module rua_sweep_ctrl (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_wr_en,
   input  wire  [rua_pkg::CFG_W-1:0]          csr_wr_data,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [rua_pkg::X_W-1:0]            req_event_x,
   input  wire  [rua_pkg::ROWF_W-1:0]         req_row_low,
   input  wire  [rua_pkg::ROWF_W-1:0]         req_row_high,
   input  wire                                req_is_close,
   input  wire                                req_first_event,
   output rua_pkg::mem_cmd_type               mem_cmd,
   input  rua_pkg::cover_type                 mem_rd_data,
   output rua_pkg::area_cmd_type              area_cmd,
   input  wire  [rua_pkg::AREA_W-1:0]         area,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [rua_pkg::AREA_W-1:0]         rsp_area,
   output logic [rua_pkg::COVROW_W-1:0]       rsp_covered_rows
);
   import rua_pkg::*;

   sweep_state_type      state_ff, state_in;
   logic [CFG_W-1:0]     rows_ff, rows_in;
   logic                 recount_ff, recount_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     snap_ff, snap_in;
   logic                 closing_ff, closing_in;
   logic [CNT_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [ROW_W-1:0]     hi_ff, hi_in;
   logic                 walk_ff, walk_in;
   logic                 pend_ff, pend_in;
   logic [ROW_W-1:0]     pend_addr_ff, pend_addr_in;
   logic [ROW_W-1:0]     clr_ptr_ff, clr_ptr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [AREA_W-1:0]    rsp_area_ff, rsp_area_in;
   logic [COVROW_W-1:0]  rsp_cov_ff, rsp_cov_in;

   logic [31:0]          rows_wide;
   logic [CNT_W-1:0]     lim;
   logic [CNT_W-1:0]     lim_m1;
   logic [CNT_W-1:0]     hi_clip;
   logic [CNT_W-1:0]     row_high_ext;
   logic                 accept;
   logic                 rsp_free;
   cover_type            old_cover;

   always_comb begin
      rows_wide = 32'(rows_ff);
      if (rows_wide == 32'd0) lim = CNT_W'(1);
      else if (rows_wide > 32'(MAX_ROWS)) lim = CNT_W'(MAX_ROWS);
      else lim = CNT_W'(rows_wide);
      lim_m1       = lim - CNT_W'(1);
      row_high_ext = CNT_W'(req_row_high);
      hi_clip      = (row_high_ext > lim_m1) ? lim_m1 : row_high_ext;
   end

   always_comb begin
      state_in     = state_ff;
      rows_in      = csr_wr_en ? csr_wr_data : rows_ff;
      recount_in   = recount_ff;
      count_in     = count_ff;
      snap_in      = snap_ff;
      closing_in   = closing_ff;
      rd_ptr_in    = rd_ptr_ff;
      hi_in        = hi_ff;
      walk_in      = 1'b0;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      clr_ptr_in   = clr_ptr_ff;
      rsp_area_in  = rsp_area_ff;
      rsp_cov_in   = rsp_cov_ff;
      rsp_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      old_cover    = mem_rd_data;
      req_ready    = 1'b0;
      accept       = 1'b0;
      mem_cmd      = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = clr_ptr_ff;
            mem_cmd.wr_data = '0;
            clr_ptr_in      = clr_ptr_ff + ROW_W'(1);
            count_in        = '0;
            if (clr_ptr_ff == ROW_W'(MAX_ROWS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (recount_ff) begin
               recount_in = 1'b0;
               count_in   = '0;
               rd_ptr_in  = '0;
               hi_in      = lim_m1[ROW_W-1:0];
               walk_in    = 1'b1;
               state_in   = ST_RECOUNT;
            end else begin
               req_ready = 1'b1;
               if (req_valid) begin
                  accept     = 1'b1;
                  snap_in    = count_ff;
                  closing_in = req_is_close;
                  rd_ptr_in  = CNT_W'(req_row_low);
                  hi_in      = hi_clip[ROW_W-1:0];
                  walk_in    = CNT_W'(req_row_low) <= hi_clip;
                  state_in   = ST_SPAN;
               end
            end
         end
         ST_RECOUNT, ST_SPAN: begin
            if (walk_ff) begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = rd_ptr_ff[ROW_W-1:0];
               rd_ptr_in       = rd_ptr_ff + CNT_W'(1);
               walk_in         = rd_ptr_ff[ROW_W-1:0] != hi_ff;
               pend_in         = 1'b1;
               pend_addr_in    = rd_ptr_ff[ROW_W-1:0];
            end
            if (pend_ff) begin
               if (state_ff == ST_RECOUNT) begin
                  if (old_cover != '0) count_in = count_ff + CNT_W'(1);
               end else begin
                  mem_cmd.wr_en   = 1'b1;
                  mem_cmd.wr_addr = pend_addr_ff;
                  mem_cmd.wr_data = cover_next(old_cover, closing_ff);
                  if (!closing_ff && old_cover == '0) count_in = count_ff + CNT_W'(1);
                  if (closing_ff && old_cover == cover_type'(1)) count_in = count_ff - CNT_W'(1);
               end
            end
            if (!walk_ff && !pend_ff) begin
               state_in = (state_ff == ST_RECOUNT) ? ST_IDLE : ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_area_in  = area;
               rsp_cov_in   = COVROW_W'(snap_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) recount_in = 1'b1;

      area_cmd.start   = accept;
      area_cmd.event_x = req_event_x;
      area_cmd.first   = req_first_event;
      area_cmd.covered = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rows_ff      <= CFG_W'(RESET_ROWS);
         recount_ff   <= 1'b0;
         count_ff     <= '0;
         walk_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         recount_ff   <= recount_in;
         count_ff     <= count_in;
         walk_ff      <= walk_in;
         pend_ff      <= pend_in;
         clr_ptr_ff   <= clr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff      <= snap_in;
      closing_ff   <= closing_in;
      rd_ptr_ff    <= rd_ptr_in;
      hi_ff        <= hi_in;
      pend_addr_ff <= pend_addr_in;
      rsp_area_ff  <= rsp_area_in;
      rsp_cov_ff   <= rsp_cov_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_area         = rsp_area_ff;
   assign rsp_covered_rows = rsp_cov_ff;

   `RUA_ASSERT(a_write_only_clear_or_span, clock, reset, mem_cmd.wr_en, (state_ff == ST_CLEAR) || (state_ff == ST_SPAN))
   `RUA_ASSERT(a_no_same_entry_overlap, clock, reset, mem_cmd.wr_en && mem_cmd.rd_en, mem_cmd.wr_addr != mem_cmd.rd_addr)
   `RUA_ASSERT(a_count_in_range, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_ROWS))
   `RUA_ASSERT_NEXT(a_accept_starts_span, clock, reset, accept, (state_ff == ST_SPAN) && !pend_ff)
   `RUA_ASSERT_NEXT(a_result_held_until_taken, clock, reset, rsp_valid_ff && !rsp_ready, rsp_valid_ff && $stable(rsp_area_ff))

endmodule
`default_nettype wire

/* rtl/core/rectangle_union_area_sweep.sv */
// Rectangle union area sweep: accepts x-sorted edge events, keeps per-row
// cover counts in a 1024-entry memory and returns the running union area with
// the covered row count seen before each event. One request yields one result.
// Each event's span is clipped to the rows in use, and a request is not taken
// until the result of the request before it has been registered. The span walk
// reads, modifies and writes one cover count per cycle through the memory's
// single read and write port. A result that is not taken holds off the next
// request. After reset a clearing pass over all 1024 entries runs before the
// first request is taken. After a write of rows_in_use the covered rows are
// recounted over the rows in use (0 counts as 1, above 1024 as 1024) before the
// next request is taken.
// Depends on rua_pkg, rua_cover_mem, rua_area_unit and rua_sweep_ctrl.
`default_nettype none
module rectangle_union_area_sweep (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_wr_en,
   input  wire  [rua_pkg::CFG_W-1:0]          csr_wr_data,      // rows_in_use
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // event_x [31:0], row_low [41:32], row_high [51:42], zero [55:52]
   input  wire  [rua_pkg::REQ_DATA_W-1:0]     req_tdata,
   // is_close [0], first_event [1]
   input  wire  [rua_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // area [62:0], covered_rows [73:63], zero [79:74]
   output logic [rua_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import rua_pkg::*;

   mem_cmd_type          mem_cmd;
   cover_type            mem_rd_data;
   area_cmd_type         area_cmd;
   logic [AREA_W-1:0]    area;
   logic [AREA_W-1:0]    rsp_area;
   logic [COVROW_W-1:0]  rsp_covered_rows;

   rua_cover_mem u_mem (
      .clock   (clock),
      .cmd     (mem_cmd),
      .rd_data (mem_rd_data)
   );

   rua_area_unit u_area (
      .clock (clock),
      .reset (reset),
      .cmd   (area_cmd),
      .area  (area)
   );

   rua_sweep_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_tvalid),
      .req_ready        (req_tready),
      .req_event_x      (req_tdata[X_W-1:0]),
      .req_row_low      (req_tdata[X_W+ROWF_W-1:X_W]),
      .req_row_high     (req_tdata[X_W+2*ROWF_W-1:X_W+ROWF_W]),
      .req_is_close     (req_tuser[0]),
      .req_first_event  (req_tuser[1]),
      .mem_cmd          (mem_cmd),
      .mem_rd_data      (mem_rd_data),
      .area_cmd         (area_cmd),
      .area             (area),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_area         (rsp_area),
      .rsp_covered_rows (rsp_covered_rows)
   );

   assign rsp_tdata = {(RSP_DATA_W - AREA_W - COVROW_W)'(0), rsp_covered_rows, rsp_area};

endmodule
`default_nettype wire

/* tb/sv/union_area_checker.sv */
// Response checker for the rectangle union area sweep: tracks register writes and
// requests, predicts the area and covered row count of each response and compares.
// Depends on rua_pkg for field widths and limits.
`timescale 1ns / 1ps
module union_area_checker (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_wr_en,
   input  wire  [rua_pkg::CFG_W-1:0]      csr_wr_data,
   input  wire                            req_tvalid,
   input  wire                            req_tready,
   input  wire  [rua_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire  [rua_pkg::REQ_USER_W-1:0] req_tuser,
   input  wire                            rsp_tvalid,
   input  wire                            rsp_tready,
   input  wire  [rua_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                             mismatch_count,
   output int                             outstanding
);
   import rua_pkg::*;

   typedef struct {
      logic [AREA_W-1:0]   area;
      logic [COVROW_W-1:0] covered;
   } area_report_type;

   logic [COVER_W-1:0] row_depth [0:MAX_ROWS-1];
   logic [CFG_W-1:0]   rows_setting;
   logic [X_W-1:0]     last_x;
   logic [63:0]        area_total;
   area_report_type    pending_reports[$];
   int                 fault_total = 0;

   assign mismatch_count = fault_total;

   task automatic sweep_event(input logic [X_W-1:0] x, input logic [ROWF_W-1:0] lo,
                              input logic [ROWF_W-1:0] hi, input logic closing,
                              input logic first, output area_report_type rep);
      int unsigned lim;
      int unsigned covered;
      int unsigned top_row;
      int          i;
      longint      step;
      logic [63:0] gain;
      lim = 32'(rows_setting);
      if (lim == 0) lim = 1;
      if (lim > MAX_ROWS) lim = MAX_ROWS;
      if (first) begin
         area_total = '0;
         last_x     = x;
      end
      covered = 0;
      for (i = 0; i < lim; i++)
         if (row_depth[i] != '0) covered++;
      step = longint'($signed(x)) - longint'($signed(last_x));
      if (step > 0) begin
         gain = 64'(step) * 64'(covered);
         if (gain > 64'(AREA_MAX) - area_total) area_total = 64'(AREA_MAX);
         else area_total = area_total + gain;
      end
      top_row = (32'(hi) > lim - 1) ? lim - 1 : 32'(hi);
      for (i = int'(lo); i <= int'(top_row); i++) begin
         if (closing) begin
            if (row_depth[i] != '0) row_depth[i] = row_depth[i] - COVER_W'(1);
         end else if (row_depth[i] != COVER_MAX) begin
            row_depth[i] = row_depth[i] + COVER_W'(1);
         end
      end
      last_x      = x;
      rep.area    = area_total[AREA_W-1:0];
      rep.covered = covered[COVROW_W-1:0];
   endtask

   always @(posedge clock) begin : watch
      area_report_type want;
      area_report_type got;
      int              i;
      if (reset) begin
         for (i = 0; i < MAX_ROWS; i++) row_depth[i] = '0;
         rows_setting = CFG_W'(RESET_ROWS);
         last_x       = '0;
         area_total   = '0;
         pending_reports.delete();
      end else begin
         if (csr_wr_en) rows_setting = csr_wr_data;
         if (req_tvalid && req_tready) begin
            sweep_event(req_tdata[X_W-1:0], req_tdata[X_W +: ROWF_W],
                        req_tdata[X_W+ROWF_W +: ROWF_W], req_tuser[0], req_tuser[1], want);
            pending_reports.insert(pending_reports.size(), want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.area    = rsp_tdata[AREA_W-1:0];
            got.covered = rsp_tdata[AREA_W +: COVROW_W];
            if (pending_reports.size() == 0) begin
               $error("unexpected response: area %0d covered_rows %0d", got.area, got.covered);
               fault_total++;
            end else begin
               want = pending_reports.pop_front();
               if (got.area !== want.area) begin
                  $error("area mismatch: expected %0d, actual %0d", want.area, got.area);
                  fault_total++;
               end
               if (got.covered !== want.covered) begin
                  $error("covered_rows mismatch: expected %0d, actual %0d",
                         want.covered, got.covered);
                  fault_total++;
               end
            end
         end
      end
      outstanding <= pending_reports.size();
   end

endmodule

/* tb/sv/testbench.sv */
// Top of the rectangle union area sweep testbench: clock, reset, request and
// register stimulus, response back-pressure and the final verdict.
// Depends on rua_pkg, rectangle_union_area_sweep and union_area_checker.
`timescale 1ns / 1ps
module testbench;
   import rua_pkg::*;

   localparam int     CLOCK_PERIOD   = 8;
   localparam int     SWEEP_ITEMS    = 1350;
   localparam int     STACK_OPENS    = 40;
   localparam longint CYCLE_LIMIT    = 10_000_000;

   typedef struct {
      logic [X_W-1:0]    x;
      logic [ROWF_W-1:0] lo;
      logic [ROWF_W-1:0] hi;
      logic              close;
      logic              first;
   } edge_event_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [CFG_W-1:0]      csr_wr_data = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [REQ_USER_W-1:0] req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    mismatch_count;
   int                    outstanding;
   bit                    calm = 1'b0;
   bit                    sender_eager = 1'b0;
   int                    sent = 0;

   rectangle_union_area_sweep uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   union_area_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin : watchdog
      longint ticks;
      for (ticks = 0; ticks < CYCLE_LIMIT; ticks++) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : receiver
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat (($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24)) @(posedge clock);
      end
   end

   task automatic send_event(input logic [X_W-1:0] x, input int lo, input int hi,
                             input bit closing, input bit first);
      if (!calm && !sender_eager && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({ROWF_W'(hi), ROWF_W'(lo), x});
      req_tuser  <= {first, closing};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic set_rows(input int rows);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CFG_W'(rows);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_sweep(input int lim);
      edge_event_type plan[$];
      edge_event_type ev;
      edge_event_type held;
      int             boxes;
      int             height;
      int             j;
      int             k;
      bit             spread;
      logic [X_W-1:0] base;
      logic [X_W-1:0] x_open;
      logic [X_W-1:0] x_close;
      boxes  = $urandom_range(1, 8);
      spread = ($urandom_range(0, 3) == 0);
      base   = $urandom();
      for (j = 0; j < boxes; j++) begin
         if (spread) begin
            x_open  = $urandom();
            x_close = $urandom();
         end else begin
            x_open  = base + $urandom_range(0, 200);
            x_close = x_open + $urandom_range(0, 60);
         end
         if ($signed(x_close) < $signed(x_open)) begin
            held.x  = x_open;
            x_open  = x_close;
            x_close = held.x;
         end
         ev.lo    = ROWF_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                        : $urandom_range(0, lim - 1));
         height   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 15);
         ev.hi    = ROWF_W'((int'(ev.lo) + height > 1023) ? 1023 : int'(ev.lo) + height);
         ev.first = 1'b0;
         ev.close = 1'b0;
         ev.x     = x_open;
         plan.insert(plan.size(), ev);
         ev.close = 1'b1;
         ev.x     = x_close;
         plan.insert(plan.size(), ev);
      end
      // order by x, opens ahead of closes at equal x
      for (j = 1; j < plan.size(); j++) begin
         held = plan[j];
         k    = j;
         while (k > 0 && ($signed(plan[k-1].x) > $signed(held.x) ||
                (plan[k-1].x == held.x && plan[k-1].close && !held.close))) begin
            plan[k] = plan[k-1];
            k--;
         end
         plan[k] = held;
      end
      if ($urandom_range(0, 7) == 0) plan.delete($urandom_range(0, plan.size() - 1));
      if ($urandom_range(0, 4) == 0) begin
         ev.x     = $urandom();
         ev.lo    = ROWF_W'($urandom());
         ev.hi    = ROWF_W'($urandom());
         ev.close = 1'($urandom());
         ev.first = ($urandom_range(0, 7) == 0);
         plan.insert($urandom_range(0, plan.size()), ev);
      end
      ev       = plan[0];
      ev.first = 1'b1;
      plan[0]  = ev;
      for (j = 0; j < plan.size(); j++)
         send_event(plan[j].x, plan[j].lo, plan[j].hi, plan[j].close, plan[j].first);
   endtask

   initial begin : stimulus
      int row_settings [14] = '{1024, 1, 2, 37, 300, 1023, 1025, 0, 512, 64, 1024, 2047,
                                700, 16};
      int random_goal;
      int phase;
      int rows;
      int lim;
      int j;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // full span, then close on every row
      send_event(32'd0, 0, 1023, 1'b0, 1'b1);
      send_event(32'd10, 0, 1023, 1'b1, 1'b0);
      send_event(32'd12, 5, 9, 1'b1, 1'b0);
      // extreme x step
      send_event(32'h8000_0000, 3, 700, 1'b0, 1'b1);
      send_event(32'h8000_0000, 1000, 1023, 1'b0, 1'b0);
      send_event(32'h7FFF_FFFF, 3, 700, 1'b1, 1'b0);
      send_event(32'd5, 10, 20, 1'b0, 1'b0);
      send_event(32'd6, 900, 100, 1'b0, 1'b0);
      send_event(32'h7FFF_FFFF, 1000, 1023, 1'b1, 1'b0);
      send_event(32'h7FFF_FFFF, 10, 20, 1'b1, 1'b0);
      // stacked opens on one row
      send_event(32'd100, 0, 0, 1'b0, 1'b1);
      send_event(32'd100, 0, 0, 1'b0, 1'b0);
      send_event(32'd101, 0, 0, 1'b1, 1'b0);
      send_event(32'd102, 0, 0, 1'b1, 1'b0);
      send_event(32'd103, 0, 0, 1'b1, 1'b0);
      set_rows(0);
      send_event(32'd0, 0, 1023, 1'b0, 1'b1);
      send_event(32'd4, 5, 9, 1'b0, 1'b0);
      send_event(32'd9, 0, 1023, 1'b1, 1'b0);
      set_rows(2047);
      send_event(-32'sd5, 1020, 1023, 1'b0, 1'b1);
      send_event(-32'sd1, 1020, 1023, 1'b1, 1'b0);
      set_rows(1024);
      send_event(32'd0, 0, 1023, 1'b0, 1'b1);
      set_rows(3);
      send_event(32'd7, 0, 1023, 1'b1, 1'b0);
      set_rows(1024);
      send_event(32'd8, 3, 1023, 1'b1, 1'b1);

      random_goal = sent + SWEEP_ITEMS;
      phase       = 0;
      while (sent < random_goal) begin
         rows = (phase < 14) ? row_settings[phase] : $urandom_range(0, 2047);
         set_rows(rows);
         lim          = (rows == 0) ? 1 : (rows > MAX_ROWS) ? MAX_ROWS : rows;
         sender_eager = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(2, 6)) run_sweep(lim);
         phase++;
      end

      // stack opens on one row, back-to-back
      set_rows(1);
      calm         = 1'b1;
      sender_eager = 1'b1;
      send_event(32'd0, 0, $urandom_range(0, 1023), 1'b0, 1'b1);
      for (j = 1; j <= STACK_OPENS; j++)
         send_event(32'(j), 0, $urandom_range(0, 1023), 1'b0, 1'b0);
      send_event(32'(STACK_OPENS + 1), 0, 0, 1'b1, 1'b0);
      send_event(32'(STACK_OPENS + 2), 0, 0, 1'b0, 1'b0);
      send_event(32'(STACK_OPENS + 3), 0, 0, 1'b0, 1'b0);
      send_event(32'(STACK_OPENS + 4), 1, 1023, 1'b1, 1'b0);

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
